[hw/rtl/tensor_legendre_basis_eval_top_defines.svh]
// ----------------------------------------------------------------------------
// tensor_legendre_basis_eval_top_defines.svh
// Assertion macros shared by the basis evaluator RTL
// ----------------------------------------------------------------------------
`ifndef TENSOR_LEGENDRE_BASIS_EVAL_TOP_DEFINES_SVH
`define TENSOR_LEGENDRE_BASIS_EVAL_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LBE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/lbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbe_pkg
// Types, constants and helpers for the tensor Legendre basis evaluator
// ----------------------------------------------------------------------------
package lbe_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int MAX_DEGREE  = 15;
	localparam int NUM_AXES    = 3;
	localparam int WIDE_W      = 48;
	// value rows stay within about +-1.0, so a narrow word holds them
	localparam int VAL_W       = 28;
	localparam int XQ_W        = 18;
	localparam int CLIP_W      = 56;
	localparam int STEP_STAGES = 4;
	localparam int LANE_LAT    = 1 + STEP_STAGES * (MAX_DEGREE - 1) + 1;
	localparam int QMUL_LAT    = 3;
	localparam int TOTAL_LAT   = LANE_LAT + 2 * QMUL_LAT;

	localparam logic [16:0] COORD_ONE = 17'd65536;
	localparam logic signed [WIDE_W-1:0] ONE_Q = WIDE_W'(64'd1 << FRAC_BITS);
	localparam logic signed [WIDE_W-1:0] LIM = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] NEG_LIM = -LIM;

	typedef struct packed {
		logic [3:0]  degree_axis0;
		logic [3:0]  degree_axis1;
		logic [3:0]  degree_axis2;
		logic [16:0] coord_axis0;
		logic [16:0] coord_axis1;
		logic [16:0] coord_axis2;
		logic [1:0]  deriv_axis;
		logic [1:0]  deriv_order;
	} in_t;

	typedef struct packed {
		logic signed [47:0] basis_value;
		logic               saturated;
	} out_t;

	// one axis lane between degree steps: windows hold rows at j-1 (a) and j-2 (b)
	typedef struct packed {
		logic signed [XQ_W-1:0]   xq;
		logic [3:0]               n;
		logic [1:0]               m;
		logic                     act;
		logic                     sat;
		logic signed [VAL_W-1:0]  v1;
		logic signed [VAL_W-1:0]  v2;
		logic [2:0][WIDE_W-1:0]   da;
		logic [2:0][WIDE_W-1:0]   db;
		logic signed [WIDE_W-1:0] sel;
	} lane_t;

	typedef struct packed {
		logic signed [WIDE_W-1:0] v;
		logic                     ovf;
	} clip_t;

	// symmetric clip to +-(2^47-1)
	function automatic clip_t clip_wide(input logic signed [CLIP_W-1:0] x);
		clip_t r;
		r.ovf = 1'b0;
		r.v   = x[WIDE_W-1:0];
		if (x > CLIP_W'(LIM)) begin
			r.ovf = 1'b1;
			r.v   = LIM;
		end else if (x < CLIP_W'(NEG_LIM)) begin
			r.ovf = 1'b1;
			r.v   = NEG_LIM;
		end
		return r;
	endfunction

endpackage

[hw/rtl/lbe_deg_step.sv]
// ----------------------------------------------------------------------------
// lbe_deg_step
// One degree step of the Legendre recurrence, four register stages
// ----------------------------------------------------------------------------
module lbe_deg_step #(
	parameter int J = 2
) (
	input  logic          clk,
	input  logic          en,
	input  lbe_pkg::lane_t lane_in,
	output lbe_pkg::lane_t lane_out
);

	localparam int K1   = 2 * J - 1;
	localparam int K2   = J - 1;
	localparam int HALF = J / 2;
	localparam logic [33:0] RECIP = 34'(((64'd1 << 34) + J - 1) / J);

	lbe_pkg::lane_t lane_s1, lane_s2, lane_s3;
	lbe_pkg::lane_t d_upd;
	lbe_pkg::lane_t d_out;
	logic signed [45:0] prod, rnd;
	logic signed [29:0] p_s1;
	logic signed [35:0] num, absn;
	logic               neg_s2, neg_s3;
	logic [29:0]        mag_s2, q_s3;
	logic [63:0]        qm;
	logic signed [lbe_pkg::VAL_W-1:0] qv, vnew;
	lbe_pkg::clip_t     c [3];
	logic signed [lbe_pkg::CLIP_W-1:0] srcx [3];

	// stage 1: x times previous value, derivative rows
	assign prod = $signed(46'(lane_in.xq)) * $signed(46'(lane_in.v1));
	assign rnd  = prod + 46'sd32768;

	always_comb begin
		d_upd = lane_in;
		srcx[0] = lbe_pkg::CLIP_W'(lane_in.v1);
		srcx[1] = lbe_pkg::CLIP_W'($signed(lane_in.da[0]));
		srcx[2] = lbe_pkg::CLIP_W'($signed(lane_in.da[1]));
		for (int r = 0; r < 3; r++) begin
			c[r] = lbe_pkg::clip_wide(lbe_pkg::CLIP_W'(K1) * srcx[r]
				+ lbe_pkg::CLIP_W'($signed(lane_in.db[r])));
			d_upd.da[r] = c[r].v;
			d_upd.db[r] = lane_in.da[r];
			if (c[r].ovf && (r < int'(lane_in.m)) && (4'(J) <= lane_in.n))
				d_upd.sat = 1'b1;
		end
		if (lane_in.n == 4'(J)) begin
			case (lane_in.m)
				2'd1:    d_upd.sel = c[0].v;
				2'd2:    d_upd.sel = c[1].v;
				2'd3:    d_upd.sel = c[2].v;
				default: d_upd.sel = lane_in.sel;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= d_upd;
			p_s1    <= rnd[45:16];
		end
	end

	// stage 2: recurrence numerator, magnitude plus half divisor
	assign num  = 36'(K1) * 36'(p_s1) - 36'(K2) * 36'(lane_s1.v2);
	assign absn = num[35] ? -num : num;

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s2 <= lane_s1;
			neg_s2  <= num[35];
			mag_s2  <= absn[29:0] + 30'(HALF);
		end
	end

	// stage 3: divide by j through the reciprocal
	assign qm = 64'(mag_s2) * 64'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s3 <= lane_s2;
			neg_s3  <= neg_s2;
			q_s3    <= qm[63:34];
		end
	end

	// stage 4: sign, slide the value window, pick the degree
	assign qv   = $signed(q_s3[lbe_pkg::VAL_W-1:0]);
	assign vnew = neg_s3 ? -qv : qv;

	always_comb begin
		d_out    = lane_s3;
		d_out.v1 = vnew;
		d_out.v2 = lane_s3.v1;
		if (lane_s3.n == 4'(J) && lane_s3.m == 2'd0)
			d_out.sel = lbe_pkg::WIDE_W'(vnew);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= d_out;
		end
	end

endmodule

[hw/rtl/lbe_lane.sv]
// ----------------------------------------------------------------------------
// lbe_lane
// One axis: coordinate mapping, degree steps, derivative scaling
// ----------------------------------------------------------------------------
module lbe_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  degree,
	input  logic [16:0] coord,
	input  logic [1:0]  m,
	input  logic        act,
	output logic signed [47:0] factor,
	output logic        sat
);

	lbe_pkg::lane_t ent;
	lbe_pkg::lane_t chain [1:lbe_pkg::MAX_DEGREE];
	logic [16:0]        cc;
	logic signed [18:0] xt;
	logic signed [lbe_pkg::XQ_W-1:0]  xq;
	logic signed [lbe_pkg::VAL_W-1:0] x1;
	lbe_pkg::clip_t     sc;

	// map the coordinate to 2c-1 and seed degrees zero and one
	assign cc = (coord > lbe_pkg::COORD_ONE) ? lbe_pkg::COORD_ONE : coord;
	assign xt = $signed({1'b0, cc, 1'b0}) - 19'sd65536;
	assign xq = xt[lbe_pkg::XQ_W-1:0];
	assign x1 = lbe_pkg::VAL_W'(xq) <<< (lbe_pkg::FRAC_BITS - 16);

	always_comb begin
		ent     = '0;
		ent.xq  = xq;
		ent.n   = degree;
		ent.m   = m;
		ent.act = act;
		ent.v1  = x1;
		ent.v2  = lbe_pkg::VAL_W'(lbe_pkg::ONE_Q);
		ent.da[0] = lbe_pkg::ONE_Q;
		if (degree == 4'd0) begin
			ent.sel = (m == 2'd0) ? lbe_pkg::ONE_Q : '0;
		end else if (degree == 4'd1) begin
			case (m)
				2'd0:    ent.sel = lbe_pkg::WIDE_W'(x1);
				2'd1:    ent.sel = lbe_pkg::ONE_Q;
				default: ent.sel = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain[1] <= ent;
		end
	end

	// degree steps two and up
	for (genvar j = 2; j <= lbe_pkg::MAX_DEGREE; j++) begin : g_step
		lbe_deg_step #(.J(j)) u_step (
			.clk      (clk),
			.en       (en),
			.lane_in  (chain[j-1]),
			.lane_out (chain[j])
		);
	end

	// chain rule scaling by 2^order, inactive axes give one
	assign sc = lbe_pkg::clip_wide(lbe_pkg::CLIP_W'(chain[lbe_pkg::MAX_DEGREE].sel)
		<<< chain[lbe_pkg::MAX_DEGREE].m);

	always_ff @(posedge clk) begin
		if (en) begin
			if (chain[lbe_pkg::MAX_DEGREE].act) begin
				factor <= sc.v;
				sat    <= chain[lbe_pkg::MAX_DEGREE].sat | sc.ovf;
			end else begin
				factor <= lbe_pkg::ONE_Q;
				sat    <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/lbe_qmul.sv]
// ----------------------------------------------------------------------------
// lbe_qmul
// Fixed-point product with rounding and saturation, three register stages
// ----------------------------------------------------------------------------
module lbe_qmul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [47:0] a,
	input  logic signed [47:0] b,
	input  logic               sat_in,
	output logic signed [47:0] prod,
	output logic               sat_out
);

	localparam int HW = 24;
	localparam int FW = 95;

	logic [47:0] ua, ub;
	logic        neg_s1, neg_s2, sat_s1, sat_s2;
	logic [47:0] p00_s1;
	logic [46:0] p01_s1, p10_s1;
	logic [45:0] p11_s1;
	logic [FW-1:0] full_s2;
	logic [70:0]   res;
	logic          ovf;
	logic [47:0]   rc;

	// stage 1: magnitudes and partial products
	assign ua = a[47] ? 48'(-a) : 48'(a);
	assign ub = b[47] ? 48'(-b) : 48'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[47] ^ b[47];
			sat_s1 <= sat_in;
			p00_s1 <= 48'(ua[HW-1:0]) * 48'(ub[HW-1:0]);
			p01_s1 <= 47'(ua[HW-1:0]) * 47'(ub[46:HW]);
			p10_s1 <= 47'(ua[46:HW]) * 47'(ub[HW-1:0]);
			p11_s1 <= 46'(ua[46:HW]) * 46'(ub[46:HW]);
		end
	end

	// stage 2: sum partial products with the rounding half
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2  <= neg_s1;
			sat_s2  <= sat_s1;
			full_s2 <= FW'(p00_s1) + (FW'(p01_s1) << HW) + (FW'(p10_s1) << HW)
				+ (FW'(p11_s1) << (2 * HW))
				+ (FW'(1) << (lbe_pkg::FRAC_BITS - 1));
		end
	end

	// stage 3: drop fraction, saturate, restore sign
	assign res = full_s2[FW-1:lbe_pkg::FRAC_BITS];
	assign ovf = res > 71'(lbe_pkg::LIM);
	assign rc  = ovf ? lbe_pkg::LIM : res[47:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod    <= neg_s2 ? -$signed(rc) : $signed(rc);
			sat_out <= sat_s2 | ovf;
		end
	end

endmodule

[hw/rtl/tensor_legendre_basis_eval_top.sv]
// ----------------------------------------------------------------------------
// tensor_legendre_basis_eval_top
// Tensor-product Legendre basis value and derivative at a point of the cube
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | in_data   (lbe_pkg::in_t)
//  out     | out       | out_valid/out_stall| out_data  (lbe_pkg::out_t)
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data  (active_axes)
//
//  One item enters per cycle unless the output stalls; the path is entry, four
//  stages for each of the fourteen degree steps, scaling, then two three-stage products.
//  arst_n clears the valid line and sets active_axes to 2.
//  A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`include "tensor_legendre_basis_eval_top_defines.svh"

module tensor_legendre_basis_eval_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lbe_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output lbe_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_data
);

	localparam logic [47:0] MIN_NEG = 48'h8000_0000_0000;

	logic [1:0]  active_q;
	logic [lbe_pkg::TOTAL_LAT-1:0] vld_q;
	logic        pipe_en;
	logic [2:0][3:0]  deg;
	logic [2:0][16:0] crd;
	logic signed [47:0] fac [3];
	logic [2:0]  lsat;
	logic signed [47:0] f2_s1, f2_s2, f2_s3, prod_a;
	logic        sat_a;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 2'd2;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// global advance and valid line
	assign pipe_en   = !out_valid || !out_stall;
	assign in_stall  = !pipe_en;
	assign out_valid = vld_q[lbe_pkg::TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[lbe_pkg::TOTAL_LAT-2:0], in_valid};
		end
	end

	// per-axis lanes
	assign deg = {in_data.degree_axis2, in_data.degree_axis1, in_data.degree_axis0};
	assign crd = {in_data.coord_axis2, in_data.coord_axis1, in_data.coord_axis0};

	for (genvar a = 0; a < lbe_pkg::NUM_AXES; a++) begin : g_lane
		logic       act;
		logic [1:0] m;
		assign act = 2'(a) < active_q;
		assign m   = (act && in_data.deriv_axis == 2'(a)) ? in_data.deriv_order : 2'd0;
		lbe_lane u_lane (
			.clk    (clk),
			.en     (pipe_en),
			.degree (deg[a]),
			.coord  (crd[a]),
			.m      (m),
			.act    (act),
			.factor (fac[a]),
			.sat    (lsat[a])
		);
	end

	// first product, third factor delayed alongside
	lbe_qmul u_qmul_a (
		.clk     (clk),
		.en      (pipe_en),
		.a       (fac[0]),
		.b       (fac[1]),
		.sat_in  (|lsat),
		.prod    (prod_a),
		.sat_out (sat_a)
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			f2_s1 <= fac[2];
			f2_s2 <= f2_s1;
			f2_s3 <= f2_s2;
		end
	end

	// second product drives the output register
	lbe_qmul u_qmul_b (
		.clk     (clk),
		.en      (pipe_en),
		.a       (prod_a),
		.b       (f2_s3),
		.sat_in  (sat_a),
		.prod    (out_data.basis_value),
		.sat_out (out_data.saturated)
	);

	// checks
	`LBE_ASSERT_NEXT(a_entry_valid, clk, arst_n, in_valid && !in_stall, vld_q[0])
	`LBE_ASSERT_NEXT(a_freeze, clk, arst_n, !pipe_en, $stable(vld_q))
	`LBE_ASSERT_IMPLY(a_sym_clip, clk, arst_n, out_valid, out_data.basis_value != MIN_NEG)

endmodule
